### hw/rtl/vfds_pkg.sv
// Shared types, constants and elaboration-time functions for the deviatoric stress unit.
`default_nettype none
package vfds_pkg;

	localparam int MAG_W      = 34;
	localparam int LG_W       = 22;
	localparam int LG_STEPS   = 16;
	localparam int EXP_STEPS  = 16;
	localparam int PIPE_DEPTH = 40;
	localparam int SIDE_LINE  = 37;
	localparam int NEWT_LINE  = 34;
	localparam int IPART_LINE = 17;

	typedef enum logic [1:0] {
		REG_VISCOSITY,
		REG_CONSISTENCY,
		REG_FLOW_EXPONENT,
		REG_INV_TIME_STEP
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] strain_xx;
		logic signed [31:0] strain_yy;
		logic signed [31:0] strain_zz;
		logic signed [31:0] shear_strain_a;
		logic signed [31:0] shear_strain_b;
		logic signed [31:0] shear_strain_c;
	} strain_t;

	typedef struct packed {
		logic signed [47:0] stress_xx;
		logic signed [47:0] stress_yy;
		logic signed [47:0] stress_zz;
		logic signed [47:0] shear_stress_a;
		logic signed [47:0] shear_stress_b;
		logic signed [47:0] shear_stress_c;
		logic               saturated;
	} stress_t;

	typedef struct packed {
		logic [31:0] viscosity;
		logic [31:0] consistency;
		logic [15:0] flow_exponent;
		logic [31:0] inv_time_step;
	} cfg_t;

	typedef struct packed {
		logic signed [47:0] stress;
		logic               sat;
	} lane_res_t;

	typedef struct packed {
		logic neg;
		logic mz;
	} side_t;

	localparam logic [63:0] MAG_POS_MAX = (64'd1 << 47) - 64'd1;
	localparam logic [63:0] MAG_NEG_MAX = 64'd1 << 47;
	// from this dividend on the quotient by three exceeds the negative limit
	localparam logic [63:0] DIV3_LIMIT  = 64'd3 * ((64'd1 << 47) + 64'd1);
	localparam logic [63:0] RECIP3_W    = ((64'd1 << 51) + 64'd1) / 64'd3;
	localparam logic [49:0] RECIP3      = RECIP3_W[49:0];

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] v;
		r = '0;
		b = 64'd1 << 62;
		v = x;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// root for fraction bit k: 2^(2^(k-16)) in Q1.30
	function automatic logic [30:0] exp_root(input int k);
		logic [63:0] root;
		root = 64'd2 << 30;
		for (int j = 15; j >= 0; j--) begin
			if (j >= k) root = isqrt64(root << 30);
		end
		return root[30:0];
	endfunction

	function automatic logic [LG_W-1:0] lg_const(input logic [MAG_W-1:0] x);
		logic [5:0]  p;
		logic [64:0] norm;
		logic [63:0] mant;
		logic [63:0] sq;
		logic [15:0] frac;
		p = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (x[i]) p = 6'(i);
		end
		norm = {x, 31'b0} >> p;
		mant = {32'b0, norm[31:0]};
		frac = '0;
		for (int i = 0; i < LG_STEPS; i++) begin
			sq = mant * mant;
			if (sq[63]) begin
				frac = frac | (16'd1 << (15 - i));
				mant = {32'b0, sq[63:32]};
			end else begin
				mant = {32'b0, sq[62:31]};
			end
		end
		return {p, frac};
	endfunction

	localparam logic [LG_W-1:0]   LG3        = lg_const(34'd3);
	localparam logic signed [23:0] CST_NORMAL = $signed(24'(LG3) + (24'd30 << 16));
	localparam logic signed [23:0] CST_SHEAR  = $signed(24'd31 << 16);

endpackage
`default_nettype wire

### hw/rtl/vfds_lg.sv
// Pipelined base-2 logarithm, Q.16 result, by repeated squaring of the mantissa.
`default_nettype none
module vfds_lg (
	input  logic                       clk,
	input  logic                       en,
	input  logic [vfds_pkg::MAG_W-1:0] x,
	output logic [vfds_pkg::LG_W-1:0]  lg
);
	import vfds_pkg::*;

	logic [5:0]  p_c;
	logic [64:0] norm_c;
	logic [31:0] mant_s [LG_STEPS+1];
	logic [5:0]  exp_s  [LG_STEPS+1];
	logic [15:0] frac_s [LG_STEPS+1];
	logic [63:0] sq_c   [LG_STEPS];
	logic [31:0] mant_nx[LG_STEPS];
	logic [15:0] frac_nx[LG_STEPS];

	always_comb begin
		p_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (x[i]) p_c = 6'(i);
		end
		// leading one lands on bit 31
		norm_c = {x, 31'b0} >> p_c;
	end

	always_comb begin
		for (int k = 0; k < LG_STEPS; k++) begin
			sq_c[k] = 64'(mant_s[k]) * 64'(mant_s[k]);
			mant_nx[k] = sq_c[k][63] ? sq_c[k][63:32] : sq_c[k][62:31];
			frac_nx[k] = frac_s[k] | (16'(sq_c[k][63]) << (15 - k));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mant_s[0] <= norm_c[31:0];
			exp_s[0]  <= p_c;
			frac_s[0] <= '0;
			for (int k = 0; k < LG_STEPS; k++) begin
				mant_s[k+1] <= mant_nx[k];
				exp_s[k+1]  <= exp_s[k];
				frac_s[k+1] <= frac_nx[k];
			end
		end
	end

	assign lg = {exp_s[LG_STEPS], frac_s[LG_STEPS]};

endmodule
`default_nettype wire

### hw/rtl/vfds_exp2.sv
// Pipelined 2^f for a 16-bit fraction, Q1.30 result, one root multiply per stage.
`default_nettype none
module vfds_exp2 (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] frac,
	output logic [30:0] acc
);
	import vfds_pkg::*;

	logic [30:0] acc_s [EXP_STEPS];
	logic [15:0] f_s   [EXP_STEPS-1];

	for (genvar j = 0; j < EXP_STEPS; j++) begin : g_stage
		localparam int          BIT_K = EXP_STEPS - 1 - j;
		localparam logic [30:0] RT    = exp_root(BIT_K);
		logic [30:0] src_acc;
		logic [15:0] src_f;
		logic [61:0] prod_c;

		always_comb begin
			if (j == 0) begin
				src_acc = 31'd1 << 30;
				src_f   = frac;
			end else begin
				src_acc = acc_s[(j == 0) ? 0 : j-1];
				src_f   = f_s[(j == 0) ? 0 : j-1];
			end
			prod_c = 62'(src_acc) * 62'(RT);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[j] <= src_f[BIT_K] ? prod_c[60:30] : src_acc;
			end
		end

		if (j < EXP_STEPS - 1) begin : g_frac
			always_ff @(posedge clk) begin
				if (en) f_s[j] <= src_f;
			end
		end
	end

	assign acc = acc_s[EXP_STEPS-1];

endmodule
`default_nettype wire

### hw/rtl/vfds_lane.sv
// One stress component: Newtonian and power-law paths, mode select and saturation.
`default_nettype none
module vfds_lane (
	input  logic                       clk,
	input  logic                       en,
	input  logic                       shear,
	input  logic signed [33:0]         dev,
	input  vfds_pkg::cfg_t             cfg,
	input  logic [63:0]                visc_rate,
	input  logic [vfds_pkg::LG_W-1:0]  lg_inv,
	output vfds_pkg::lane_res_t        res
);
	import vfds_pkg::*;

	logic                neg_s2;
	logic [MAG_W-1:0]    m_s2;
	side_t               side_s3 [SIDE_LINE];

	// Newtonian path
	logic [65:0]         pp_lo_s3, pp_hi_s3;
	logic [97:0]         nprod_c;
	logic [63:0]         nx_c;
	logic                novf_c, nbig_c;
	logic [48:0]         nx49_c;
	logic [48:0]         nx_s4;
	logic                nbig_s4;
	logic [49:0]         dp_ll_s5, dp_lh_s5, dp_hl_s5, dp_hh_s5;
	logic [47:0]         nx_s5;
	logic                nbig_s5;
	logic [99:0]         qsum_c;
	logic [48:0]         newt_s6 [NEWT_LINE];

	// power-law path
	logic [LG_W-1:0]     lg_m;
	logic signed [23:0]  lsum_s20;
	logic signed [40:0]  ymul_c;
	logic signed [28:0]  y_s21;
	logic [12:0]         ipart_s22 [IPART_LINE];
	logic [30:0]         acc_p;
	logic [62:0]         prod_s38;
	logic signed [13:0]  sh_c, nsh_c;
	logic [62:0]         pmag_c;
	logic                pbig_c;
	logic [62:0]         pmag_s39;
	logic                pbig_s39;

	// final select
	side_t               side_c;
	logic [63:0]         mag_c;
	logic                over_c, zero_c;
	logic [47:0]         m48_c;
	lane_res_t           res_c, res_s40;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= dev[33];
			m_s2   <= dev[33] ? (~dev + 34'd1) : dev;
			side_s3[0] <= '{neg: neg_s2, mz: (m_s2 == '0)};
			for (int i = 1; i < SIDE_LINE; i++) side_s3[i] <= side_s3[i-1];
		end
	end

	// Newtonian: rate product in two halves, then divide by three via reciprocal on normal lanes
	always_ff @(posedge clk) begin
		if (en) begin
			pp_lo_s3 <= 66'(m_s2) * 66'(visc_rate[31:0]);
			pp_hi_s3 <= 66'(m_s2) * 66'(visc_rate[63:32]);
		end
	end

	always_comb begin
		nprod_c = 98'(pp_lo_s3) + (98'(pp_hi_s3) << 32);
		if (shear) begin
			nx_c   = nprod_c[94:31];
			novf_c = |nprod_c[97:95];
			nbig_c = novf_c || (|nx_c[63:48]);
			nx49_c = {1'b0, nx_c[47:0]};
		end else begin
			nx_c   = nprod_c[93:30];
			novf_c = |nprod_c[97:94];
			nbig_c = novf_c || (nx_c >= DIV3_LIMIT);
			nx49_c = nx_c[48:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s4    <= nx49_c;
			nbig_s4  <= nbig_c;
			dp_ll_s5 <= 50'(nx_s4[24:0]) * 50'(RECIP3[24:0]);
			dp_lh_s5 <= 50'(nx_s4[24:0]) * 50'(RECIP3[49:25]);
			dp_hl_s5 <= 50'(nx_s4[48:25]) * 50'(RECIP3[24:0]);
			dp_hh_s5 <= 50'(nx_s4[48:25]) * 50'(RECIP3[49:25]);
			nx_s5    <= nx_s4[47:0];
			nbig_s5  <= nbig_s4;
		end
	end

	assign qsum_c = 100'(dp_ll_s5) + (100'(dp_lh_s5) << 25) + (100'(dp_hl_s5) << 25)
		+ (100'(dp_hh_s5) << 50);

	always_ff @(posedge clk) begin
		if (en) begin
			newt_s6[0] <= {nbig_s5, shear ? nx_s5 : qsum_c[98:51]};
			for (int i = 1; i < NEWT_LINE; i++) newt_s6[i] <= newt_s6[i-1];
		end
	end

	// power law: log, scale by exponent, exp2, scale by consistency, shift by integer part
	vfds_lg u_lg (
		.clk (clk),
		.en  (en),
		.x   (m_s2),
		.lg  (lg_m)
	);

	assign ymul_c = $signed({1'b0, cfg.flow_exponent}) * lsum_s20;

	always_ff @(posedge clk) begin
		if (en) begin
			lsum_s20 <= $signed(24'(lg_m)) + $signed(24'(lg_inv))
				- (shear ? CST_SHEAR : CST_NORMAL);
			y_s21 <= ymul_c[40:12];
			ipart_s22[0] <= y_s21[28:16];
			for (int i = 1; i < IPART_LINE; i++) ipart_s22[i] <= ipart_s22[i-1];
		end
	end

	vfds_exp2 u_exp2 (
		.clk  (clk),
		.en   (en),
		.frac (y_s21[15:0]),
		.acc  (acc_p)
	);

	always_comb begin
		sh_c   = $signed({ipart_s22[IPART_LINE-1][12], ipart_s22[IPART_LINE-1]}) - 14'sd30;
		nsh_c  = -sh_c;
		pmag_c = '0;
		pbig_c = 1'b0;
		if (sh_c > 14'sd0) begin
			if (sh_c >= 14'sd47) begin
				pbig_c = 1'b1;
			end else begin
				pbig_c = (prod_s38 >> (6'd47 - sh_c[5:0])) != '0;
				pmag_c = prod_s38 << sh_c[5:0];
			end
		end else if (nsh_c <= 14'sd62) begin
			pmag_c = prod_s38 >> nsh_c[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s38 <= 63'(cfg.consistency) * 63'(acc_p);
			pmag_s39 <= pmag_c;
			pbig_s39 <= pbig_c;
		end
	end

	always_comb begin
		side_c = side_s3[SIDE_LINE-1];
		mag_c  = '0;
		over_c = 1'b0;
		zero_c = 1'b0;
		if (cfg.viscosity != '0) begin
			mag_c  = {16'b0, newt_s6[NEWT_LINE-1][47:0]};
			over_c = newt_s6[NEWT_LINE-1][48];
		end else if (cfg.consistency != '0) begin
			if (cfg.flow_exponent == '0) begin
				mag_c = {32'b0, cfg.consistency};
			end else if (side_c.mz || (cfg.inv_time_step == '0)) begin
				zero_c = 1'b1;
			end else begin
				mag_c  = {1'b0, pmag_s39};
				over_c = pbig_s39;
			end
		end else begin
			zero_c = 1'b1;
		end

		res_c.sat = 1'b0;
		m48_c = mag_c[47:0];
		if (side_c.neg) begin
			if (over_c || (mag_c > MAG_NEG_MAX)) begin
				res_c.sat = 1'b1;
				m48_c = MAG_NEG_MAX[47:0];
			end
			res_c.stress = $signed(~m48_c + 48'd1);
		end else begin
			if (over_c || (mag_c > MAG_POS_MAX)) begin
				res_c.sat = 1'b1;
				m48_c = MAG_POS_MAX[47:0];
			end
			res_c.stress = $signed(m48_c);
		end
		if (zero_c) begin
			res_c.stress = '0;
			res_c.sat    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_s40 <= res_c;
	end

	assign res = res_s40;

endmodule
`default_nettype wire

### hw/rtl/viscous_fluid_deviatoric_stress_unit.sv
// Top level of the viscous fluid deviatoric stress unit.
`default_nettype none
// Takes one strain-increment tensor per cycle while not stalled and returns its deviatoric
// stress; fully pipelined, unstalled throughput is one tensor per clock. Latency is set by
// the 16-stage squaring chain of the log2 unit and the 16-stage root-multiply chain of the
// exp2 unit in each of the six component lanes. On an output stall the pipeline holds and
// strain_stall rises in the same cycle. The user must write config only after the pipeline
// drains, so writes take effect on the next item accepted; the block does not enforce it.
module viscous_fluid_deviatoric_stress_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              strain_valid,
	output logic              strain_stall,
	input  vfds_pkg::strain_t strain,
	output logic              stress_valid,
	input  logic              stress_stall,
	output vfds_pkg::stress_t stress,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import vfds_pkg::*;

	localparam logic [5:0] SHEAR_LANES = 6'b111000;

	logic                   adv;
	logic [PIPE_DEPTH-1:0]  vld_q;
	strain_t                strain_s1;
	cfg_t                   cfg_q;
	logic [63:0]            visc_rate_q;
	logic signed [33:0]     e_c   [6];
	logic signed [33:0]     sum_c;
	logic signed [33:0]     dev_c [6];
	logic [LG_W-1:0]        lg_inv;
	lane_res_t              lane_res [6];
	logic [5:0]             sat_c;
	logic [5:0]             at_lim_c;

	assign adv          = !(stress_valid && stress_stall);
	assign strain_stall = !adv;
	assign stress_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], strain_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) strain_s1 <= strain;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.viscosity     <= '0;
			cfg_q.consistency   <= '0;
			cfg_q.flow_exponent <= 16'd4096;
			cfg_q.inv_time_step <= 32'd1;
			visc_rate_q         <= '0;
		end else begin
			visc_rate_q <= 64'(cfg_q.viscosity) * 64'(cfg_q.inv_time_step);
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_VISCOSITY:     cfg_q.viscosity     <= cfg_data;
					REG_CONSISTENCY:   cfg_q.consistency   <= cfg_data;
					REG_FLOW_EXPONENT: cfg_q.flow_exponent <= cfg_data[15:0];
					REG_INV_TIME_STEP: cfg_q.inv_time_step <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// normal deviation kept exact as 3*e - trace
	always_comb begin
		e_c[0] = 34'(strain_s1.strain_xx);
		e_c[1] = 34'(strain_s1.strain_yy);
		e_c[2] = 34'(strain_s1.strain_zz);
		e_c[3] = 34'(strain_s1.shear_strain_a);
		e_c[4] = 34'(strain_s1.shear_strain_b);
		e_c[5] = 34'(strain_s1.shear_strain_c);
		sum_c  = e_c[0] + e_c[1] + e_c[2];
		for (int i = 0; i < 6; i++) begin
			if (i < 3) dev_c[i] = (e_c[i] <<< 1) + e_c[i] - sum_c;
			else       dev_c[i] = e_c[i];
		end
	end

	vfds_lg u_lg_inv (
		.clk (clk),
		.en  (adv),
		.x   ({2'b0, cfg_q.inv_time_step}),
		.lg  (lg_inv)
	);

	for (genvar i = 0; i < 6; i++) begin : g_lane
		vfds_lane u_lane (
			.clk       (clk),
			.en        (adv),
			.shear     (SHEAR_LANES[i]),
			.dev       (dev_c[i]),
			.cfg       (cfg_q),
			.visc_rate (visc_rate_q),
			.lg_inv    (lg_inv),
			.res       (lane_res[i])
		);
		assign sat_c[i]    = lane_res[i].sat;
		assign at_lim_c[i] = (lane_res[i].stress == $signed(MAG_POS_MAX[47:0]))
			|| (lane_res[i].stress == $signed(MAG_NEG_MAX[47:0]));
	end

	always_comb begin
		stress.stress_xx      = lane_res[0].stress;
		stress.stress_yy      = lane_res[1].stress;
		stress.stress_zz      = lane_res[2].stress;
		stress.shear_stress_a = lane_res[3].stress;
		stress.shear_stress_b = lane_res[4].stress;
		stress.shear_stress_c = lane_res[5].stress;
		stress.saturated      = |sat_c;
	end

	a_valid_advances: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_q[PIPE_DEPTH-2] |=> stress_valid)
		else $error("valid lost between last stage and output");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		strain_stall |-> stress_valid && stress_stall)
		else $error("input stalled without a stalled result");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		stress_valid && stress.saturated |-> at_lim_c != '0)
		else $error("saturated flag without a clipped component");

endmodule
`default_nettype wire

### bench/viscous_fluid_deviatoric_stress_unit_tb.sv
// Self-checking bench for the deviatoric stress unit: directed table, then random config phases.
`timescale 1ns / 100ps
`default_nettype none
module viscous_fluid_deviatoric_stress_unit_tb;
	import vfds_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        strain_valid;
	logic        strain_stall;
	strain_t     strain;
	logic        stress_valid;
	logic        stress_stall;
	stress_t     stress;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	viscous_fluid_deviatoric_stress_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.strain_valid(strain_valid), .strain_stall(strain_stall), .strain(strain),
		.stress_valid(stress_valid), .stress_stall(stress_stall), .stress(stress),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct {
		cfg_t    cfg;
		strain_t s;
		bit      typed;
		stress_t want;
	} row_t;

	cfg_t    cur_cfg;
	stress_t stress_due[$];
	int      errors;
	int      sent;
	int      checked;
	int      phases;
	bit      quiet;
	int      stall_left;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// log2 of x >= 1 in Q.16, fraction from repeated squaring of a Q1.31 mantissa
	function automatic longint log2_q16(longint unsigned x);
		int p;
		longint unsigned mant;
		longint r;
		p = 63;
		while (p > 0 && !x[p]) p--;
		mant = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
		r = longint'(p) * 65536;
		for (int i = 0; i < 16; i++) begin
			mant = (mant * mant) >> 31;
			if (mant >= (64'd1 << 32)) begin
				r += longint'(1) << (15 - i);
				mant >>= 1;
			end
		end
		return r;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// 2^f for a 16-bit fraction, Q1.30
	function automatic longint unsigned exp2_q30(logic [15:0] f);
		longint unsigned acc, root;
		acc = 64'd1 << 30;
		root = 64'd2 << 30;
		for (int k = 15; k >= 0; k--) begin
			root = int_sqrt(root << 30);
			if (f[k]) acc = (acc * root) >> 30;
		end
		return acc;
	endfunction

	function automatic logic [47:0] clip48(bit neg, longint unsigned mag, bit over,
			inout bit sat);
		if (neg) begin
			if (over || mag > (64'd1 << 47)) begin
				sat = 1'b1;
				mag = 64'd1 << 47;
			end
			return 48'(~mag + 64'd1);
		end
		if (over || mag > ((64'd1 << 47) - 1)) begin
			sat = 1'b1;
			mag = (64'd1 << 47) - 1;
		end
		return 48'(mag);
	endfunction

	function automatic logic [47:0] power_law_stress(bit neg, longint unsigned m,
			longint cst, inout bit sat);
		longint lg, y, ip, sh;
		longint unsigned prod, mag;
		if (cur_cfg.flow_exponent == 0) return clip48(neg, cur_cfg.consistency, 0, sat);
		if (m == 0 || cur_cfg.inv_time_step == 0) return '0;
		lg = log2_q16(m) + log2_q16(cur_cfg.inv_time_step) - cst;
		y = (longint'(cur_cfg.flow_exponent) * lg) >>> 12;
		ip = y >>> 16;
		prod = longint'(cur_cfg.consistency) * exp2_q30(y[15:0]);
		sh = ip - 30;
		if (sh > 0) begin
			if (sh >= 47 || (prod >> (47 - sh)) != 0) return clip48(neg, 0, 1, sat);
			mag = prod << sh;
		end else begin
			mag = (-sh >= 64) ? 0 : (prod >> (-sh));
		end
		return clip48(neg, mag, 0, sat);
	endfunction

	function automatic stress_t deviatoric_stress(strain_t s);
		longint e[6];
		longint sum, d;
		longint unsigned m, rate;
		logic [127:0] prod;
		logic [47:0] o[6];
		bit sat, neg;
		stress_t r;
		e[0] = s.strain_xx;
		e[1] = s.strain_yy;
		e[2] = s.strain_zz;
		e[3] = s.shear_strain_a;
		e[4] = s.shear_strain_b;
		e[5] = s.shear_strain_c;
		sat = 0;
		sum = e[0] + e[1] + e[2];
		for (int i = 0; i < 6; i++) begin
			d = (i < 3) ? (3 * e[i] - sum) : e[i];
			neg = d < 0;
			m = neg ? -d : d;
			if (cur_cfg.viscosity != 0) begin
				rate = longint'(cur_cfg.viscosity) * longint'(cur_cfg.inv_time_step);
				prod = (128'(rate) * 128'(m)) >> ((i < 3) ? 30 : 31);
				o[i] = clip48(neg, (i < 3) ? prod[63:0] / 3 : prod[63:0],
					|prod[127:64], sat);
			end else if (cur_cfg.consistency != 0) begin
				o[i] = power_law_stress(neg, m,
					(i < 3) ? log2_q16(3) + 30 * 65536 : 31 * 65536, sat);
			end else begin
				o[i] = '0;
			end
		end
		r.stress_xx = o[0];
		r.stress_yy = o[1];
		r.stress_zz = o[2];
		r.shear_stress_a = o[3];
		r.shear_stress_b = o[4];
		r.shear_stress_c = o[5];
		r.saturated = sat;
		return r;
	endfunction

	task automatic report(string field, logic [47:0] got, logic [47:0] want);
		if (got !== want) begin
			errors++;
			$display("mismatch %s at %0t: got %h want %h", field, $realtime, got, want);
		end
	endtask

	always @(posedge clk) begin
		stress_t want;
		if (arst_n && stress_valid && !stress_stall) begin
			if (stress_due.size() == 0) begin
				errors++;
				$display("unexpected stress transfer at %0t", $realtime);
			end else begin
				want = stress_due.pop_front();
				checked++;
				report("stress_xx", stress.stress_xx, want.stress_xx);
				report("stress_yy", stress.stress_yy, want.stress_yy);
				report("stress_zz", stress.stress_zz, want.stress_zz);
				report("shear_stress_a", stress.shear_stress_a, want.shear_stress_a);
				report("shear_stress_b", stress.shear_stress_b, want.shear_stress_b);
				report("shear_stress_c", stress.shear_stress_c, want.shear_stress_c);
				report("saturated", 48'(stress.saturated), 48'(want.saturated));
			end
		end
	end

	// output back-pressure in short bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stress_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stress_stall <= 1'b1;
			stall_left <= $urandom_range(0, 3);
		end else begin
			stress_stall <= 1'b0;
		end
	end

	task automatic put(strain_t s, bit typed = 0, stress_t want = '0);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			strain_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		strain <= s;
		strain_valid <= 1'b1;
		@(posedge clk);
		while (strain_stall) @(posedge clk);
		stress_due.push_back(typed ? want : deviatoric_stress(s));
		sent++;
	endtask

	task automatic apply_cfg(cfg_t c);
		strain_valid <= 1'b0;
		while (stress_due.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= 2'(i);
			case (cfg_reg_t'(i))
				REG_VISCOSITY:     cfg_data <= c.viscosity;
				REG_CONSISTENCY:   cfg_data <= c.consistency;
				REG_FLOW_EXPONENT: cfg_data <= 32'(c.flow_exponent);
				REG_INV_TIME_STEP: cfg_data <= c.inv_time_step;
				default:           cfg_data <= '0;
			endcase
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		cur_cfg = c;
		phases++;
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return $urandom_range(1, 70000);
			2: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_strain();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'($urandom_range(0, 4000)) - 32'd2000;
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return 32'($signed($urandom) >>> $urandom_range(0, 28));
			default: return $urandom;
		endcase
	endfunction

	function automatic strain_t rand_strain();
		strain_t s;
		s.strain_xx = pick_strain();
		s.strain_yy = pick_strain();
		s.strain_zz = pick_strain();
		s.shear_strain_a = pick_strain();
		s.shear_strain_b = pick_strain();
		s.shear_strain_c = pick_strain();
		return s;
	endfunction

	function automatic cfg_t rand_cfg(int n);
		cfg_t c;
		c.viscosity = pick32();
		c.consistency = pick32();
		c.inv_time_step = pick32();
		case ($urandom_range(0, 4))
			0: c.flow_exponent = 16'd0;
			1: c.flow_exponent = 16'd4096;
			2: c.flow_exponent = 16'hFFFF;
			default: c.flow_exponent = $urandom_range(0, 12000);
		endcase
		// favor power-law mode, it has the most logic
		if ($urandom_range(0, 1)) c.viscosity = 32'd0;
		if (n == 0) c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF};
		if (n == 1) c = '{32'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF};
		if (n == 2) c = '{32'd0, 32'd1, 16'd1, 32'd1};
		return c;
	endfunction

	row_t plan[$];

	task automatic add_row(cfg_t c, strain_t s, bit typed = 0, stress_t want = '0);
		row_t r;
		r.cfg = c;
		r.s = s;
		r.typed = typed;
		r.want = want;
		plan.push_back(r);
	endtask

	localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_MAX = 48'h8000_0000_0000;

	initial begin
		cfg_t reset_cfg, newt, plaw, expo0, no_rate, sat_cfg;
		strain_t big, mixed;
		stress_t zero_res;
		arst_n = 1'b0;
		strain_valid <= 1'b0;
		strain <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sent = 0;
		checked = 0;
		phases = 0;
		quiet = 0;
		reset_cfg = '{32'd0, 32'd0, 16'd4096, 32'd1};
		cur_cfg = reset_cfg;
		newt = '{32'h0001_8000, 32'd0, 16'd4096, 32'd60};
		plaw = '{32'd0, 32'h0002_0000, 16'd2048, 32'd1000};
		expo0 = '{32'd0, 32'h0003_0000, 16'd0, 32'd5};
		no_rate = '{32'd0, 32'd5, 16'd4096, 32'd0};
		sat_cfg = '{32'hFFFF_FFFF, 32'd7, 16'd4096, 32'hFFFF_FFFF};
		big = '{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
		mixed = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h4000_0000};
		zero_res = '0;

		// zero mode after reset gives zeros, whatever the strain; then Newtonian and power-law rows
		add_row(reset_cfg, '0, 1, zero_res);
		add_row(reset_cfg, big, 1, zero_res);
		add_row(reset_cfg, '1, 1, zero_res);
		add_row(newt, '0, 1, zero_res);
		add_row(newt, big);
		add_row(newt, mixed);
		add_row(newt, '{32'd3, -32'd3, 32'd1, 32'd2, -32'd2, 32'd1000});
		add_row(plaw, mixed);
		add_row(plaw, '{32'h0100_0000, 32'h0, 32'hFF00_0000, 32'h0010_0000, 32'h0, 32'h1});
		// exponent zero: consistency exactly, zero component counts as positive
		add_row(expo0, '0, 1, '{48'h3_0000, 48'h3_0000, 48'h3_0000,
			48'h3_0000, 48'h3_0000, 48'h3_0000, 1'b0});
		add_row(expo0, '{32'd0, 32'd0, 32'd5, -32'd1, 32'd0, 32'd9}, 1,
			'{-48'sh3_0000, -48'sh3_0000, 48'h3_0000,
			-48'sh3_0000, 48'h3_0000, 48'h3_0000, 1'b0});
		// zero rate from inv_time_step of zero
		add_row(no_rate, mixed, 1, zero_res);
		add_row(no_rate, big, 1, zero_res);
		add_row(sat_cfg, big, 1, '{POS_MAX, NEG_MAX, NEG_MAX, NEG_MAX, POS_MAX,
			48'h0, 1'b1});
		add_row(sat_cfg, mixed);
		add_row('{32'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF}, big);
		add_row('{32'hFFFF_FFFF, 32'd9, 16'd0, 32'd1}, mixed);
		add_row('{32'd0, 32'd1, 16'd1, 32'd1}, '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].cfg != cur_cfg) apply_cfg(plan[i].cfg);
			put(plan[i].s, plan[i].typed, plan[i].want);
		end

		for (int ph = 0; ph < 10; ph++) begin
			apply_cfg(rand_cfg(ph));
			if (ph == 9) quiet = 1;
			for (int n = 0; n < 113; n++) put(rand_strain());
		end
		strain_valid <= 1'b0;
		while (stress_due.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);

		$display("sent %0d strain tensors, checked %0d stress results", sent, checked);
		$display("%0d register settings, Newtonian, power-law and zero modes", phases);
		if (errors == 0) begin
			$display("[viscous_fluid_deviatoric_stress_unit] OK");
		end else begin
			$display("[viscous_fluid_deviatoric_stress_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("timeout with %0d results outstanding", stress_due.size());
		$display("[viscous_fluid_deviatoric_stress_unit] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
